### hdl/wlir_pkg.sv
// shared constants and types of the wrapping linear interpolation resampler
package wlir_pkg;

	localparam int BUF_DEPTH  = 1024;
	localparam int ADDR_W     = $clog2(BUF_DEPTH);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int SAMPLE_W   = 16;
	localparam int RATIO_W    = 18;
	localparam int FRAC_W     = 16;
	localparam int POS_W      = LEN_W + RATIO_W;
	localparam int INT_W      = POS_W - FRAC_W;
	localparam int STEP_W     = $clog2(INT_W + 1);
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [RATIO_W-1:0] RATIO_UNITY = RATIO_W'(65536);
	localparam logic [RATIO_W-1:0] BYPASS_TOL  = RATIO_W'(65);
	localparam logic [RATIO_W-1:0] BYPASS_LO   = RATIO_UNITY - BYPASS_TOL;
	localparam logic [RATIO_W-1:0] BYPASS_HI   = RATIO_UNITY + BYPASS_TOL;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// word select bit of the register map: register 0 lives at byte 0
	localparam logic REG_RATIO_SEL = 1'b0;

	typedef struct packed {
		logic             start;
		logic [INT_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] rem;
	} mod_rsp_t;

endpackage

### hdl/wlir_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
module wlir_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  wlir_pkg::mod_req_t req,
	output wlir_pkg::mod_rsp_t rsp
);
	import wlir_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [INT_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  dvs_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[INT_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = trial - {1'b0, dvs_q};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(INT_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[INT_W-2:0], 1'b0};
			// remainder stays below the divisor, so the top bit is always clear
			rem_q <= rem_next[LEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### hdl/wrapping_linear_interp_resampler.sv
// top level of the wrapping linear interpolation resampler
// A push transaction stores one signed Q1.15 sample in a 1024-entry single
// read, single write sample memory, or drops it when the memory is full; the
// push with block_end set closes the block, and the next push starts a new
// one. A pull transaction returns the next output sample of the closed block:
// output i reads the block at position i*ratio_q16 (Q16), wraps the integer
// part modulo the block length and interpolates linearly with the next (also
// wrapped) sample, truncating toward minus infinity. To form the result of a
// pull, the integer part of the read position is reduced by a bit-serial
// remainder unit that settles one bit per cycle, followed by two memory reads
// (current and next sample through the one read port), a multiply, an add
// and the load of the output register; the input is free again from the
// cycle in which the result turns valid. With ratio_q16 at zero or within
// 65/65536 of unity the remainder step is skipped and output i copies sample
// i. A pull with no closed block or past its end goes straight to the output
// register with pull_error set. The result sits in an output register, so the
// block takes new transactions while a result waits; only one pull is in
// flight at a time, and a pull that finds an earlier result still waiting
// holds until that result is taken. There is no clearing pass after reset:
// the memory is only read below the current block length.
module wrapping_linear_interp_resampler (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wlir_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [wlir_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [wlir_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [wlir_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                block_end,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wlir_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                final_of_block,
	output logic                                pull_error
);
	import wlir_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_RDB  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_SUM  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	// sample memory
	logic signed [SAMPLE_W-1:0] mem [BUF_DEPTH];
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [ADDR_W-1:0]          mem_raddr;
	logic signed [SAMPLE_W-1:0] rd_q;

	// control state
	logic [2:0]         state_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [LEN_W-1:0]   len_q;
	logic               ready_q;
	logic [LEN_W-1:0]   count_q;

	// pull datapath
	logic [ADDR_W-1:0]          idx_q;
	logic [ADDR_W-1:0]          nxt_q;
	logic [FRAC_W-1:0]          frac_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       fin_q;
	logic                       err_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_fin_q;
	logic                       out_err_q;

	logic               cfg_wr;
	logic               in_acc;
	logic               push_acc;
	logic               pull_acc;
	logic               pull_bad;
	logic               bypass;
	logic [LEN_W-1:0]   len_eff;
	logic [POS_W-1:0]   pos;
	logic [LEN_W:0]     rem_inc;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-DIFF_W-1:0] interp;
	logic               emit;
	mod_req_t           mod_req;
	mod_rsp_t           mod_rsp;

	// register access, writes ignored for addresses past the map
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RATIO_SEL);
	assign prdata = (paddr[2] == REG_RATIO_SEL) ? APB_DATA_W'(ratio_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_UNITY;
		end else if (cfg_wr) begin
			ratio_q <= pwdata[RATIO_W-1:0];
		end
	end

	// handshake: new transactions only between pulls
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign push_acc = in_acc && (opcode == OP_PUSH);
	assign pull_acc = in_acc && (opcode == OP_PULL);

	// a closed block is restarted by the next push
	assign len_eff  = ready_q ? '0 : len_q;
	assign pull_bad = !ready_q || (len_q == '0) || (count_q >= len_q);
	assign bypass   = (ratio_q == '0) || ((ratio_q >= BYPASS_LO) && (ratio_q <= BYPASS_HI));

	// read position of this output, integer part still unwrapped
	assign pos = POS_W'(count_q) * POS_W'(ratio_q);

	assign mod_req.start    = pull_acc && !pull_bad && !bypass;
	assign mod_req.dividend = pos[POS_W-1:FRAC_W];
	assign mod_req.divisor  = len_q;

	wlir_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// next sample index, wrapped at the block end
	assign rem_inc = {1'b0, mod_rsp.rem} + 1'b1;

	// memory ports
	assign mem_we    = push_acc && (len_eff < LEN_W'(BUF_DEPTH));
	assign mem_waddr = len_eff[ADDR_W-1:0];
	assign mem_raddr = (state_q == S_RDB) ? nxt_q : idx_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= sample_in;
		end
		rd_q <= mem[mem_raddr];
	end

	assign diff   = DIFF_W'(rd_q) - DIFF_W'(a_q);
	// floor of the scaled difference
	assign interp = prod_q[FRAC_W+DIFF_W-1:FRAC_W];
	assign emit   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			ready_q <= 1'b0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (push_acc) begin
						// a full store drops the sample but still takes block_end
						if (len_eff < LEN_W'(BUF_DEPTH)) begin
							len_q <= len_eff + 1'b1;
						end else begin
							len_q <= len_eff;
						end
						if (ready_q) begin
							count_q <= '0;
						end
						ready_q <= block_end;
					end else if (pull_acc) begin
						if (pull_bad) begin
							state_q <= S_EMIT;
						end else if (bypass) begin
							state_q <= S_RDA;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (mod_rsp.done) begin
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: begin
					count_q <= count_q + 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pull datapath registers
	always_ff @(posedge clk) begin
		if (pull_acc) begin
			if (pull_bad) begin
				res_q <= '0;
				fin_q <= 1'b0;
				err_q <= 1'b1;
			end else begin
				err_q <= 1'b0;
			end
			if (bypass) begin
				// plain copy: both reads hit the same entry with no fraction
				idx_q  <= count_q[ADDR_W-1:0];
				nxt_q  <= count_q[ADDR_W-1:0];
				frac_q <= '0;
			end else begin
				frac_q <= pos[FRAC_W-1:0];
			end
		end
		if ((state_q == S_DIV) && mod_rsp.done) begin
			idx_q <= mod_rsp.rem[ADDR_W-1:0];
			if (rem_inc == {1'b0, len_q}) begin
				nxt_q <= '0;
			end else begin
				nxt_q <= rem_inc[ADDR_W-1:0];
			end
		end
		if (state_q == S_RDB) begin
			a_q <= rd_q;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_q}));
		end
		if (state_q == S_SUM) begin
			res_q <= SAMPLE_W'(PROD_W'(a_q) + PROD_W'(interp));
			fin_q <= ((count_q + 1'b1) == len_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sample_q <= res_q;
			out_fin_q    <= fin_q;
			out_err_q    <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_out     = out_sample_q;
	assign final_of_block = out_fin_q;
	assign pull_error     = out_err_q;

endmodule

### hdl/wlir_checker.sv
// port-level checks of the resampler and their binding to the top level
module wlir_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                pready,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                opcode,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [wlir_pkg::SAMPLE_W-1:0] sample_out,
	input logic                                final_of_block,
	input logic                                pull_error
);
	import wlir_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out)
			&& $stable(final_of_block) && $stable(pull_error))
		else $error("result changed while stalled");

	// an error result carries no sample and never closes a block
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pull_error |-> (sample_out == '0) && !final_of_block)
		else $error("error result with live fields");

	// a pull keeps the input side busy in the next cycle
	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_PULL) |=> in_stall)
		else $error("input taken while a pull is in flight");

	// a pull never yields a result in the cycle right after acceptance
	a_pull_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_PULL) && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind wrapping_linear_interp_resampler wlir_checker u_wlir_checker (.*);

### tb/sv/wlir_checker.sv
// output checker of the resampler: mirrors its state, predicts every pull and compares
module wlir_scoreboard (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [wlir_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [wlir_pkg::APB_DATA_W-1:0]      pwdata,
	input  logic                                 pready,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [wlir_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 block_end,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [wlir_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 final_of_block,
	input  logic                                 pull_error,
	output int                                   pending,
	output int                                   mismatches
);
	import wlir_pkg::*;

	localparam logic [APB_ADDR_W-1:0] RATIO_ADDR = {REG_RATIO_SEL, 2'b00};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       fin;
		logic                       err;
	} out_sample_t;

	out_sample_t                awaited[$];
	out_sample_t                want;
	out_sample_t                got;
	logic signed [SAMPLE_W-1:0] store [BUF_DEPTH];
	int unsigned                blk_len;
	int unsigned                emitted;
	bit                         blk_closed;
	logic [RATIO_W-1:0]         ratio;
	int                         bad;
	int                         nseen;

	function automatic void take_sample(logic signed [SAMPLE_W-1:0] smp, logic closes);
		if (blk_closed) begin
			blk_len = 0;
			blk_closed = 1'b0;
			emitted = 0;
		end
		// a full store drops the sample but still honours the closing flag
		if (blk_len < BUF_DEPTH) begin
			store[blk_len] = smp;
			blk_len++;
		end
		if (closes)
			blk_closed = 1'b1;
	endfunction

	function automatic out_sample_t next_output();
		out_sample_t     r;
		longint unsigned pos;
		int unsigned     base;
		int unsigned     succ;
		int unsigned     gap;
		longint          a;
		longint          b;
		longint          mix;
		r = '0;
		if (!blk_closed || blk_len == 0 || emitted >= blk_len) begin
			r.err = 1'b1;
			return r;
		end
		gap = ratio > RATIO_UNITY ? ratio - RATIO_UNITY : RATIO_UNITY - ratio;
		if (ratio == '0 || gap <= BYPASS_TOL) begin
			mix = store[emitted];
		end else begin
			pos = longint'(emitted) * longint'(ratio);
			base = int'((pos >> FRAC_W) % blk_len);
			succ = (base + 1) % blk_len;
			a = store[base];
			b = store[succ];
			// arithmetic shift floors toward minus infinity
			mix = a + (((b - a) * longint'(pos[FRAC_W-1:0])) >>> FRAC_W);
		end
		r.smp = mix[SAMPLE_W-1:0];
		r.fin = (emitted + 1 == blk_len);
		emitted++;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited.delete();
			blk_len = 0;
			emitted = 0;
			blk_closed = 1'b0;
			ratio = RATIO_UNITY;
			bad = 0;
			nseen = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			// results first, so a result can never match a pull taken on the same edge
			if (out_valid && !out_stall) begin
				got = {sample_out, final_of_block, pull_error};
				nseen++;
				if (awaited.size() == 0) begin
					if (bad < 10)
						$display("output transaction %0d arrived with nothing expected", nseen);
					bad++;
				end else begin
					want = awaited.pop_front();
					if (got.smp !== want.smp || got.fin !== want.fin || got.err !== want.err) begin
						if (bad < 10)
							$display("mismatch on output %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								nseen, $signed(want.smp), want.fin, want.err,
								$signed(got.smp), got.fin, got.err);
						bad++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == RATIO_ADDR)
				ratio = pwdata[RATIO_W-1:0];
			if (in_valid && !in_stall) begin
				if (opcode == OP_PUSH)
					take_sample(sample_in, block_end);
				else
					awaited.push_back(next_output());
			end
			pending <= awaited.size();
			mismatches <= bad;
		end
	end

endmodule

### tb/sv/wrapping_linear_interp_resampler_tb.sv
// testbench top of the resampler: stimulus, handshake pacing and the final verdict
module wrapping_linear_interp_resampler_tb;
	import wlir_pkg::*;

	localparam int QUIET_LIMIT   = 20000;
	localparam int LONG_HOLD     = 400;
	// margin that covers any work still under way
	localparam int SETTLE_CYCLES = 32;
	localparam logic [APB_ADDR_W-1:0] RATIO_ADDR = {REG_RATIO_SEL, 2'b00};
	localparam logic [APB_DATA_W-1:0] RATIO_MASK = APB_DATA_W'((1 << RATIO_W) - 1);
	localparam logic [RATIO_W-1:0]    ONE_AND_HALF = RATIO_UNITY + (RATIO_UNITY >> 1);
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_MAX = ~S_MIN;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]      paddr = '0;
	logic [APB_DATA_W-1:0]      pwdata = '0;
	logic [APB_DATA_W-1:0]      prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       opcode = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       block_end = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       final_of_block;
	logic                       pull_error;

	int pending;
	int mismatches;

	// pacing: percentage of cycles in which each side holds back
	int send_pct = 0;
	int recv_pct = 0;
	// each increment asks the receiver for one long hold-off
	int hold_calls = 0;
	int items_sent = 0;

	always #5 clk = ~clk;

	wrapping_linear_interp_resampler DUT (.*);

	wlir_scoreboard checker_i (.*);

	// receiver: random stall, or a long hold-off when asked so that the block backs up
	always @(posedge clk) begin
		int hold_left;
		int hold_served;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_served != hold_calls) begin
			hold_served = hold_calls;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	// watchdog: ends the run once nothing has moved for too long
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one input transaction, with random gaps in front of it; returns after acceptance
	task automatic send_item(logic op, logic signed [SAMPLE_W-1:0] smp, logic closes);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample_in <= smp;
		block_end <= closes;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// full-scale values turn up often so the interpolation sees its extremes
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(logic signed [SAMPLE_W-1:0] smp, logic closes);
		send_item(OP_PUSH, smp, closes);
	endtask

	// sample and flag are meaningless on a pull, so they carry noise
	task automatic pull_sample();
		send_item(OP_PULL, rand_sample(), 1'($urandom_range(1)));
	endtask

	task automatic feed_block(int len, int pulls);
		for (int k = 0; k < len; k++)
			push_sample(rand_sample(), k == len - 1);
		repeat (pulls) pull_sample();
	endtask

	// sender pauses until every awaited result is in and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access phase; bits above the ratio field carry noise
	task automatic write_ratio(logic [RATIO_W-1:0] r);
		settle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= RATIO_ADDR;
		pwdata <= ($urandom() & ~RATIO_MASK) | APB_DATA_W'(r);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// bypass edges on both sides of unity, the extremes, and plenty of plain random ratios
	function automatic logic [RATIO_W-1:0] pick_ratio();
		case ($urandom_range(11))
			0: return '0;
			1: return RATIO_W'(1);
			2: return BYPASS_LO - RATIO_W'(1);
			3: return BYPASS_LO;
			4: return RATIO_UNITY;
			5: return BYPASS_HI;
			6: return BYPASS_HI + RATIO_W'(1);
			7: return '1;
			8: return RATIO_W'($urandom_range(1, 65535));
			9, 10: return RATIO_W'($urandom_range(65536, 262143));
			default: return RATIO_W'($urandom);
		endcase
	endfunction

	// mostly whole blocks with random content; some noise, open blocks and retuning
	task automatic random_traffic(int budget);
		int start;
		int pick;
		int len;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_item(1'($urandom_range(1)), rand_sample(), 1'($urandom_range(1)));
			end else if (pick < 10) begin
				write_ratio(pick_ratio());
			end else if (pick < 16) begin
				// pulls against a block that is still open are refused
				repeat ($urandom_range(1, 4)) push_sample(rand_sample(), 1'b0);
				repeat ($urandom_range(1, 2)) pull_sample();
			end else begin
				pick = $urandom_range(99);
				len = pick < 70 ? $urandom_range(1, 8) :
					pick < 95 ? $urandom_range(9, 48) : $urandom_range(49, 200);
				// read the whole block, now and then run past its end or walk away early
				if ($urandom_range(99) < 15)
					feed_block(len, $urandom_range(0, len - 1));
				else
					feed_block(len, len + $urandom_range(0, 2));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pull with nothing loaded
		pull_sample();
		// pull while the block is still open
		push_sample(S_MIN, 1'b0);
		push_sample(S_MAX, 1'b0);
		pull_sample();
		// close it; unity ratio passes the samples straight through, the fourth pull overruns
		push_sample('0, 1'b1);
		repeat (4) pull_sample();
		// full-scale swings at a ratio of 1.5, so the halfway fraction floors a negative step
		write_ratio(ONE_AND_HALF);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b0);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b1);
		repeat (5) pull_sample();
		// zero ratio is also a pass-through
		write_ratio('0);
		push_sample(S_MIN, 1'b0);
		push_sample(S_MAX, 1'b1);
		repeat (2) pull_sample();

		// sender mostly busy, receiver mostly stalled, top ratio
		send_pct = 32;
		recv_pct <= 86;
		write_ratio('1);
		hold_calls <= hold_calls + 1;
		feed_block(40, 42);
		random_traffic(70);

		// sender sparse, receiver mostly ready, just inside the bypass window
		send_pct = 86;
		recv_pct <= 32;
		write_ratio(BYPASS_LO);
		random_traffic(70);

		// no idling on either side, just outside the bypass window
		send_pct = 0;
		recv_pct <= 0;
		write_ratio(BYPASS_HI + RATIO_W'(1));
		hold_calls <= hold_calls + 1;
		feed_block(40, 41);
		// overfill the store: the last two samples are dropped, the closing flag still counts
		feed_block(BUF_DEPTH + 2, 6);
		random_traffic(50);

		settle();
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
hdl/wlir_pkg.sv
hdl/wlir_mod.sv
hdl/wrapping_linear_interp_resampler.sv
hdl/wlir_checker.sv
tb/sv/wlir_checker.sv
tb/sv/wrapping_linear_interp_resampler_tb.sv
